FILE: design/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the priority scheduler with aging.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned Levels     = 4;
  localparam int unsigned FifoDepth  = 16;
  localparam int unsigned HandleBits = 16;
  localparam int unsigned LvlW       = $clog2(Levels);
  localparam int unsigned PtrW       = $clog2(FifoDepth);
  localparam int unsigned CntW       = $clog2(FifoDepth + 1);
  localparam int unsigned Entries    = Levels * FifoDepth;
  localparam int unsigned AddrW      = $clog2(Entries);
  localparam int unsigned TotW       = 7;
  localparam int unsigned QuotaW     = 8;
  localparam logic [QuotaW-1:0] QuotaReset = 8'd4;

  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [HandleBits-1:0] task_handle;
    logic [1:0]            priority_level;
  } req_t;

  typedef struct packed {
    logic [HandleBits-1:0] popped_handle;
    logic                  popped_valid;
    logic                  push_dropped;
    logic [TotW-1:0]       total_queued;
  } rsp_t;

  // decision handed from front to back
  typedef struct packed {
    logic             is_pop;
    logic             hit;
    logic             dropped;
    logic [AddrW-1:0] addr;
    logic [TotW-1:0]  total;
  } cmd_t;

endpackage

FILE: design/pfs_if.sv
// ----------------------------------------------------------------------------
// pfs_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface pfs_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/pfs_ram.sv
// ----------------------------------------------------------------------------
// pfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

FILE: design/pfs_front.sv
// ----------------------------------------------------------------------------
// pfs_front
// Pointer, count and aging bookkeeping; picks the level for each request.
// ----------------------------------------------------------------------------
module pfs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pfs_pkg::QuotaW-1:0] quota_i,
  input  logic                       valid_i,
  input  pfs_pkg::req_t              req_i,
  output logic                       ready_o,
  output logic                       cmd_valid_o,
  output pfs_pkg::cmd_t              cmd_o,
  input  logic                       cmd_ready_i,
  output logic                       we_o,
  output logic [pfs_pkg::AddrW-1:0]  waddr_o
);
  import pfs_pkg::*;

  logic [PtrW-1:0]   head_q [Levels];
  logic [PtrW-1:0]   tail_q [Levels];
  logic [CntW-1:0]   cnt_q  [Levels];
  logic [QuotaW-1:0] skip_q [Levels];
  logic [TotW-1:0]   total_q;
  logic              fire, full, starved_hit, any_hit;
  logic [LvlW-1:0]   sel, starved_sel, prio_sel, plvl;

  assign ready_o     = cmd_ready_i;
  assign cmd_valid_o = valid_i;
  assign fire        = valid_i && cmd_ready_i;
  assign plvl        = req_i.priority_level[LvlW-1:0];
  assign full        = (cnt_q[plvl] == CntW'(FifoDepth));

  always_comb begin
    starved_hit = 1'b0;
    starved_sel = '0;
    any_hit     = 1'b0;
    prio_sel    = '0;
    for (int i = Levels - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0 && skip_q[i] >= quota_i) begin
        starved_hit = 1'b1;
        starved_sel = LvlW'(i);
      end
      if (cnt_q[i] != '0) begin
        any_hit  = 1'b1;
        prio_sel = LvlW'(i);
      end
    end
    sel = starved_hit ? starved_sel : prio_sel;
  end

  always_comb begin
    cmd_o.is_pop  = (req_i.opcode == OpPop);
    cmd_o.hit     = any_hit;
    cmd_o.dropped = (req_i.opcode == OpPush) && full;
    cmd_o.addr    = {sel, head_q[sel]};
    cmd_o.total   = total_q;
    if (req_i.opcode == OpPush && !full) begin
      cmd_o.total = total_q + 1'b1;
    end else if (req_i.opcode == OpPop && any_hit) begin
      cmd_o.total = total_q - 1'b1;
    end
  end

  assign we_o    = fire && req_i.opcode == OpPush && !full;
  assign waddr_o = {plvl, tail_q[plvl]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Levels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
        skip_q[i] <= '0;
      end
      total_q <= '0;
    end else if (fire) begin
      total_q <= cmd_o.total;
      if (we_o) begin
        tail_q[plvl] <= (tail_q[plvl] == PtrW'(FifoDepth - 1)) ? '0 : tail_q[plvl] + 1'b1;
        cnt_q[plvl]  <= cnt_q[plvl] + 1'b1;
      end else if (req_i.opcode == OpPop && any_hit) begin
        head_q[sel] <= (head_q[sel] == PtrW'(FifoDepth - 1)) ? '0 : head_q[sel] + 1'b1;
        cnt_q[sel]  <= cnt_q[sel] - 1'b1;
        if (starved_hit) begin
          skip_q[sel] <= '0;
        end else begin
          for (int j = 0; j < Levels; j++) begin
            if (LvlW'(j) > sel && cnt_q[j] != '0 && skip_q[j] < quota_i) begin
              skip_q[j] <= skip_q[j] + 1'b1;
            end
          end
        end
      end
    end
  end

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotW'(Entries)) else $error("total count overflow");
  a_no_drop_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && req_i.opcode == OpPop |-> !cmd_o.dropped) else $error("pop flagged drop");
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && req_i.opcode == OpPop && !any_hit |-> total_q == '0)
    else $error("empty pop with tasks queued");
endmodule

FILE: design/pfs_back.sv
// ----------------------------------------------------------------------------
// pfs_back
// Reads the task store and forms the result behind a one-entry queue.
// ----------------------------------------------------------------------------
module pfs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  pfs_pkg::cmd_t             cmd_i,
  output logic                      cmd_ready_o,
  output logic                      re_o,
  output logic [pfs_pkg::AddrW-1:0] raddr_o,
  input  logic [pfs_pkg::HandleBits-1:0] rdata_i,
  output logic                      valid_o,
  output pfs_pkg::rsp_t             rsp_o,
  input  logic                      ready_i
);
  import pfs_pkg::*;

  logic stg_q, stg_d;
  cmd_t cmd_q;
  logic accept;

  // stage holds one command whose RAM read is in flight / waiting
  assign cmd_ready_o = !stg_q || ready_i;
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign re_o        = accept;
  assign raddr_o     = cmd_i.addr;
  assign stg_d       = accept ? 1'b1 : (ready_i ? 1'b0 : stg_q);
  assign valid_o     = stg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= 1'b0;
    end else begin
      stg_q <= stg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  always_comb begin
    rsp_o.popped_valid  = cmd_q.is_pop && cmd_q.hit;
    rsp_o.popped_handle = rsp_o.popped_valid ? rdata_i : '0;
    rsp_o.push_dropped  = cmd_q.dropped;
    rsp_o.total_queued  = cmd_q.total;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_q && !ready_i |=> stg_q && $stable(cmd_q)) else $error("result lost");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_q |-> !(rsp_o.popped_valid && rsp_o.push_dropped)) else $error("pop and drop");
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> stg_q) else $error("stage not filled");
endmodule

FILE: design/priority_fifo_scheduler_with_aging_core.sv
// ----------------------------------------------------------------------------
// priority_fifo_scheduler_with_aging_core
// Four-level task FIFO scheduler with starvation aging.
// ----------------------------------------------------------------------------
// One transaction per cycle: a push or pop is accepted every clock while the
// result stage is free or being drained, and its result appears in the cycle
// after, from the registered read of the shared task store RAM. The front
// keeps per-level head/tail/count and skip counters and picks the level with
// a small priority encoder (starved levels first, then priority); the back
// holds the RAM read and the finished result until the sink takes it.
module priority_fifo_scheduler_with_aging_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pfs_pkg::QuotaW-1:0] cfg_wdata_i,
  pfs_if.sink                        req_if,
  pfs_if.source                      rsp_if
);
  import pfs_pkg::*;

  logic [QuotaW-1:0]     quota_q;
  logic                  cmd_valid, cmd_ready, we, re;
  cmd_t                  cmd;
  logic [AddrW-1:0]      waddr, raddr;
  logic [HandleBits-1:0] rdata;

  // quota register; the user writes it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q <= QuotaReset;
    end else if (cfg_we_i) begin
      quota_q <= cfg_wdata_i;
    end
  end

  pfs_front u_front (
    .clk_i, .rst_ni,
    .quota_i     (quota_q),
    .valid_i     (req_if.valid),
    .req_i       (req_if.data),
    .ready_o     (req_if.ready),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready),
    .we_o        (we),
    .waddr_o     (waddr)
  );

  pfs_ram #(.Width(HandleBits), .Depth(Entries)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_if.data.task_handle),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pfs_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .valid_o     (rsp_if.valid),
    .rsp_o       (rsp_if.data),
    .ready_i     (rsp_if.ready)
  );
endmodule

FILE: tb/priority_fifo_scheduler_with_aging_core_tb.sv
// ----------------------------------------------------------------------------
// priority_fifo_scheduler_with_aging_core_tb
// Self-checking bench: directed table then bursty random push/pop traffic,
// scoreboarded against a behavioral scheduler model across several quotas.
// ----------------------------------------------------------------------------
module priority_fifo_scheduler_with_aging_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfs_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [QuotaW-1:0] cfg_wdata_i;

  pfs_if #(.T(req_t)) req_if ();
  pfs_if #(.T(rsp_t)) rsp_if ();

  priority_fifo_scheduler_with_aging_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_if     (req_if),
    .rsp_if     (rsp_if)
  );

  // Scheduler model state
  logic [HandleBits-1:0] sched_store [Levels][FifoDepth];
  int unsigned           sched_head  [Levels];
  int unsigned           sched_tail  [Levels];
  int unsigned           sched_cnt   [Levels];
  int unsigned           sched_skip  [Levels];
  int unsigned           sched_quota;

  rsp_t        sched_rsp_q [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned rsp_seen;
  int unsigned pop_hits;
  int unsigned drop_seen;

  localparam int unsigned CycleLimit = 400000;

  // Directed table row: an expectation is typed in only where obvious.
  typedef struct {
    req_t req;
    bit   has_exp;
    rsp_t exp;
  } row_t;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsp_t sched_take(int unsigned lvl);
    rsp_t r;
    r = '0;
    r.popped_handle = sched_store[lvl][sched_head[lvl]];
    r.popped_valid  = 1'b1;
    sched_head[lvl] = (sched_head[lvl] + 1) % FifoDepth;
    sched_cnt[lvl]--;
    return r;
  endfunction

  // Advance the model by one transaction and return the predicted response.
  function automatic rsp_t sched_predict(req_t req);
    rsp_t        r;
    int unsigned lvl;
    int unsigned tot;
    bit          served;
    r      = '0;
    lvl    = req.priority_level;
    served = 1'b0;
    tot    = 0;
    if (req.opcode == OpPush) begin
      if (lvl >= Levels || sched_cnt[lvl] >= FifoDepth) begin
        r.push_dropped = 1'b1;
      end else begin
        sched_store[lvl][sched_tail[lvl]] = req.task_handle;
        sched_tail[lvl] = (sched_tail[lvl] + 1) % FifoDepth;
        sched_cnt[lvl]++;
      end
    end else begin
      // starved levels get served first, lowest index wins
      for (int i = 0; i < Levels; i++) begin
        if (!served && sched_skip[i] >= sched_quota && sched_cnt[i] != 0) begin
          r = sched_take(i);
          sched_skip[i] = 0;
          served = 1'b1;
        end
      end
      for (int i = 0; i < Levels; i++) begin
        if (!served && sched_cnt[i] != 0) begin
          r = sched_take(i);
          served = 1'b1;
          // age every waiting lower level, saturate at the quota
          for (int j = i + 1; j < Levels; j++) begin
            if (sched_cnt[j] != 0 && sched_skip[j] < sched_quota) sched_skip[j]++;
          end
        end
      end
    end
    for (int i = 0; i < Levels; i++) tot += sched_cnt[i];
    r.total_queued = tot[TotW-1:0];
    return r;
  endfunction

  // Hold the request and wait until the block takes it.
  task automatic send_req(req_t req);
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Push the prediction at the accept edge, then drop valid unless the next
  // transaction follows back to back.
  task automatic issue(req_t req, bit back_to_back);
    send_req(req);
    sched_rsp_q.push_back(sched_predict(req));
    if (!back_to_back) req_if.valid <= 1'b0;
  endtask

  // Drain all outstanding results plus a small settle time.
  task automatic drain_wait();
    while (sched_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_quota(logic [QuotaW-1:0] q);
    drain_wait();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sched_quota = q;
  endtask

  function automatic req_t rand_req(int unsigned pop_pct);
    req_t r;
    r.opcode         = ($urandom_range(99) < pop_pct) ? OpPop : OpPush;
    r.task_handle    = HandleBits'($urandom());
    r.priority_level = 2'($urandom_range(Levels - 1));
    return r;
  endfunction

  // Receiver: stall on a pattern that shifts between phases, and check.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_seen++;
        if (sched_rsp_q.size() == 0) begin
          $error("unexpected response %p", rsp_if.data);
          fail_cnt++;
        end else begin
          rsp_t e;
          e = sched_rsp_q.pop_front();
          if (rsp_if.data.popped_handle !== e.popped_handle) begin
            $error("popped_handle exp %h act %h", e.popped_handle, rsp_if.data.popped_handle);
            fail_cnt++;
          end
          if (rsp_if.data.popped_valid !== e.popped_valid) begin
            $error("popped_valid exp %b act %b", e.popped_valid, rsp_if.data.popped_valid);
            fail_cnt++;
          end
          if (rsp_if.data.push_dropped !== e.push_dropped) begin
            $error("push_dropped exp %b act %b", e.push_dropped, rsp_if.data.push_dropped);
            fail_cnt++;
          end
          if (rsp_if.data.total_queued !== e.total_queued) begin
            $error("total_queued exp %0d act %0d", e.total_queued, rsp_if.data.total_queued);
            fail_cnt++;
          end
          if (e.popped_valid) pop_hits++;
          if (e.push_dropped) drop_seen++;
        end
      end
      // long ready-high runs alternate with stall-heavy stretches
      if ((cycle_cnt / 200) % 3 == 0) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(3) != 0) || (cycle_cnt[2:0] == 3'd5);
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CycleLimit) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("priority_fifo_scheduler_with_aging_core verification failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    row_t        dir_tbl [$];
    row_t        row;
    req_t        req;
    int unsigned sent;
    int unsigned burst;
    int unsigned pop_pct;
    logic [QuotaW-1:0] quota_set [5];

    fail_cnt     = 0;
    rsp_seen     = 0;
    pop_hits     = 0;
    drop_seen    = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    sched_quota  = QuotaReset;
    for (int i = 0; i < Levels; i++) begin
      sched_head[i] = 0;
      sched_tail[i] = 0;
      sched_cnt[i]  = 0;
      sched_skip[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop right after reset
    row = '{req: '{OpPop, 16'hFFFF, 2'd3}, has_exp: 1, exp: '{16'h0, 1'b0, 1'b0, 7'd0}};
    dir_tbl.push_back(row);
    // extreme handles on both ends of the level range
    row = '{req: '{OpPush, 16'hFFFF, 2'd3}, has_exp: 1, exp: '{16'h0, 1'b0, 1'b0, 7'd1}};
    dir_tbl.push_back(row);
    row = '{req: '{OpPush, 16'h0000, 2'd0}, has_exp: 1, exp: '{16'h0, 1'b0, 1'b0, 7'd2}};
    dir_tbl.push_back(row);
    row = '{req: '{OpPop, 16'h0, 2'd0}, has_exp: 1, exp: '{16'h0000, 1'b1, 1'b0, 7'd1}};
    dir_tbl.push_back(row);
    row = '{req: '{OpPop, 16'h0, 2'd0}, has_exp: 1, exp: '{16'hFFFF, 1'b1, 1'b0, 7'd0}};
    dir_tbl.push_back(row);
    // fill level 1 up to depth, then one more push must drop
    for (int i = 0; i <= FifoDepth; i++) begin
      row = '{req: '{OpPush, 16'hA500 + 16'(i), 2'd1}, has_exp: 0, exp: '0};
      dir_tbl.push_back(row);
    end
    // mixed pushes and pops for aging with the reset quota
    row = '{req: '{OpPush, 16'h5A5A, 2'd2}, has_exp: 0, exp: '0};
    dir_tbl.push_back(row);
    for (int i = 0; i < 4; i++) begin
      row = '{req: '{OpPop, 16'h0, 2'd0}, has_exp: 0, exp: '0};
      dir_tbl.push_back(row);
    end

    foreach (dir_tbl[k]) begin
      send_req(dir_tbl[k].req);
      sched_rsp_q.push_back(sched_predict(dir_tbl[k].req));
      if (dir_tbl[k].has_exp && sched_rsp_q[$] != dir_tbl[k].exp) begin
        $error("directed row %0d: table %p model %p", k, dir_tbl[k].exp, sched_rsp_q[$]);
        fail_cnt++;
      end
    end
    req_if.valid <= 1'b0;

    // Random phases at several quotas, zero and max among them
    quota_set = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd4};
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_quota(quota_set[ph]);
      for (int n = 0; n < 180; n += burst) begin
        burst   = $urandom_range(1, 24);
        // swing the push/pop mix so levels fill to full and drain to empty
        pop_pct = ((n / 60) % 2 == 0) ? 30 : 70;
        for (int b = 0; b < burst; b++) begin
          req = rand_req(pop_pct);
          issue(req, b != burst - 1);
          sent++;
        end
        // idle between bursts so valid drops before the next burst
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end

    drain_wait();
    $display("sent %0d transactions over 5 quota settings plus directed rows", sent);
    $display("checked %0d responses: %0d pops served, %0d pushes dropped",
             rsp_seen, pop_hits, drop_seen);
    if (fail_cnt == 0) begin
      $display("priority_fifo_scheduler_with_aging_core verification clean");
    end else begin
      $display("priority_fifo_scheduler_with_aging_core verification failed");
    end
    $finish;
  end

endmodule
